@@ rtl/text_console_writer_unit_defines.svh @@
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, masked while rst is high.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, masked while rst is high.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
// Shared constants, command codes and queue entry type of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int OP_W   = 2;

  localparam int FIFO_DEPTH = 2;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] idx;
  } cmd_entry_t;

endpackage

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tcw_front.sv @@
// Front end: takes input requests and turns them into console commands.
`timescale 1ns / 1ps
module tcw_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::OP_W-1:0]     op,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]   cell_index,
  input  logic                         q_full,
  input  logic                         init_busy,
  output logic                         push,
  output tcw_pkg::cmd_entry_t          push_entry
);

  logic idx_in_range;

  assign in_ready     = !q_full && !init_busy;
  assign push         = in_valid && in_ready;
  assign idx_in_range = cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT);

  always_comb begin
    push_entry.ch  = char_code;
    push_entry.idx = cell_index;
    unique case (op)
      tcw_pkg::OP_PUT: begin
        if (char_code == tcw_pkg::CH_NUL) begin
          push_entry.cmd = tcw_pkg::CMD_NOP;
        end else if (char_code == tcw_pkg::CH_NEWLINE) begin
          push_entry.cmd = tcw_pkg::CMD_NEWLINE;
        end else if (char_code == tcw_pkg::CH_BACKSPACE) begin
          push_entry.cmd = tcw_pkg::CMD_BACKSPACE;
        end else begin
          push_entry.cmd = tcw_pkg::CMD_PUT;
        end
      end
      tcw_pkg::OP_CLEAR: push_entry.cmd = tcw_pkg::CMD_CLEAR;
      // out-of-range reads return zero, same as a no-op
      tcw_pkg::OP_READ:  push_entry.cmd = idx_in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
      default:           push_entry.cmd = tcw_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ rtl/tcw_fifo.sv @@
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
`include "text_console_writer_unit_defines.svh"
module tcw_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tcw_pkg::cmd_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output tcw_pkg::cmd_entry_t q_entry
);

  localparam int PTR_W = (tcw_pkg::FIFO_DEPTH > 1) ? $clog2(tcw_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::FIFO_DEPTH + 1);

  tcw_pkg::cmd_entry_t entries [tcw_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full    = count == CNT_W'(tcw_pkg::FIFO_DEPTH);
  assign q_valid = count != '0;
  assign q_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tcw_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tcw_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TCW_ASSERT_NOW(a_fifo_no_underflow, pop, count != '0, "command popped from empty queue")
  `TCW_ASSERT_NOW(a_fifo_count_range, 1'b1, count <= CNT_W'(tcw_pkg::FIFO_DEPTH), "queue count over depth")

endmodule

@@ rtl/tcw_back.sv @@
// Back end: cursor, screen store, scroll and clear sweeps, result register.
`timescale 1ns / 1ps
`include "text_console_writer_unit_defines.svh"
module tcw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
  input  logic                        q_valid,
  input  tcw_pkg::cmd_entry_t         q_entry,
  output logic                        pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::ROW_W-1:0]   caret_row,
  output logic [tcw_pkg::COL_W-1:0]   caret_col,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data
);

  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int CELL_W = tcw_pkg::CELL_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_FILL   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic [ADDR_W-1:0]          cnt, cnt_next;
  logic [ADDR_W-1:0]          dst, dst_next;
  logic                       copy_pend, copy_pend_next;
  logic [CELL_W-1:0]          fill_cell, fill_cell_next;
  logic                       fill_result, fill_result_next;
  logic [ROW_W-1:0]           row, row_next;
  logic [COL_W-1:0]           col, col_next;
  logic [tcw_pkg::ATTR_W-1:0] attr;

  logic                       out_free;
  logic                       emit;
  logic [ROW_W-1:0]           emit_row;
  logic [COL_W-1:0]           emit_col;
  logic [CELL_W-1:0]          emit_data;

  logic [ROW_W-1:0]           bs_row;
  logic [COL_W-1:0]           bs_col;
  logic [ADDR_W-1:0]          cursor_addr;
  logic [ADDR_W-1:0]          bs_addr;
  logic [CELL_W-1:0]          blank_cell;

  logic                       we;
  logic [ADDR_W-1:0]          waddr;
  logic [CELL_W-1:0]          wdata;
  logic                       re;
  logic [ADDR_W-1:0]          raddr;
  logic [CELL_W-1:0]          rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free   = !out_valid || out_ready;
  assign pop        = (state == S_IDLE) && q_valid && out_free;
  assign init_busy  = (state == S_FILL) && !fill_result;
  assign blank_cell = {attr, tcw_pkg::CH_SPACE};

  // backspace target: step left, wrap to previous row, stick at home
  always_comb begin
    bs_row = row;
    bs_col = col;
    if (col != '0) begin
      bs_col = col - 1'b1;
    end else if (row != '0) begin
      bs_row = row - 1'b1;
      bs_col = COL_W'(tcw_pkg::COLUMNS - 1);
    end
  end

  assign cursor_addr = ADDR_W'(row) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col);
  assign bs_addr     = ADDR_W'(bs_row) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(bs_col);

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    dst_next         = dst;
    copy_pend_next   = 1'b0;
    fill_cell_next   = fill_cell;
    fill_result_next = fill_result;
    row_next         = row;
    col_next         = col;
    emit             = 1'b0;
    emit_row         = row;
    emit_col         = col;
    emit_data        = '0;
    we               = 1'b0;
    waddr            = cnt;
    wdata            = fill_cell;
    re               = 1'b0;
    raddr            = cnt;

    unique case (state)
      S_IDLE: begin
        if (pop) begin
          unique case (q_entry.cmd)
            tcw_pkg::CMD_PUT: begin
              we    = 1'b1;
              waddr = cursor_addr;
              wdata = {attr, q_entry.ch};
              if (col == COL_W'(tcw_pkg::COLUMNS - 1)) begin
                col_next = '0;
                if (row == ROW_W'(tcw_pkg::ROWS - 1)) begin
                  state_next = S_SCROLL;
                  cnt_next   = '0;
                end else begin
                  row_next = row + 1'b1;
                  emit     = 1'b1;
                  emit_row = row + 1'b1;
                  emit_col = '0;
                end
              end else begin
                col_next = col + 1'b1;
                emit     = 1'b1;
                emit_col = col + 1'b1;
              end
            end
            tcw_pkg::CMD_NEWLINE: begin
              col_next = '0;
              if (row == ROW_W'(tcw_pkg::ROWS - 1)) begin
                state_next = S_SCROLL;
                cnt_next   = '0;
              end else begin
                row_next = row + 1'b1;
                emit     = 1'b1;
                emit_row = row + 1'b1;
                emit_col = '0;
              end
            end
            tcw_pkg::CMD_BACKSPACE: begin
              we       = 1'b1;
              waddr    = bs_addr;
              wdata    = blank_cell;
              row_next = bs_row;
              col_next = bs_col;
              emit     = 1'b1;
              emit_row = bs_row;
              emit_col = bs_col;
            end
            tcw_pkg::CMD_CLEAR: begin
              row_next         = '0;
              col_next         = '0;
              state_next       = S_FILL;
              cnt_next         = '0;
              fill_cell_next   = blank_cell;
              fill_result_next = 1'b1;
            end
            tcw_pkg::CMD_READ: begin
              re         = 1'b1;
              raddr      = q_entry.idx;
              state_next = S_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // read data holds while the result register is full
        if (out_free) begin
          emit       = 1'b1;
          emit_data  = rdata;
          state_next = S_IDLE;
        end
      end
      S_SCROLL: begin
        // copy each cell one row up: read source now, write it in the next cycle
        if (copy_pend) begin
          we    = 1'b1;
          waddr = dst;
          wdata = rdata;
        end
        if (cnt < ADDR_W'(tcw_pkg::LAST_BASE)) begin
          re             = 1'b1;
          raddr          = ADDR_W'(cnt + ADDR_W'(tcw_pkg::COLUMNS));
          copy_pend_next = 1'b1;
          dst_next       = cnt;
          cnt_next       = cnt + 1'b1;
        end else begin
          state_next       = S_FILL;
          fill_cell_next   = blank_cell;
          fill_result_next = 1'b1;
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (cnt == ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
          state_next = fill_result ? S_DONE : S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      cnt         <= '0;
      copy_pend   <= 1'b0;
      fill_cell   <= {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
      fill_result <= 1'b0;
      row         <= '0;
      col         <= '0;
      attr        <= tcw_pkg::RESET_ATTR;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      copy_pend   <= copy_pend_next;
      fill_cell   <= fill_cell_next;
      fill_result <= fill_result_next;
      row         <= row_next;
      col         <= col_next;
      if (cfg_valid) begin
        attr <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dst <= dst_next;
    if (emit) begin
      caret_row <= emit_row;
      caret_col <= emit_col;
      cell_data <= emit_data;
    end
  end

  `TCW_ASSERT_NOW(a_col_range, 1'b1, col < COL_W'(tcw_pkg::COLUMNS), "cursor column out of range")
  `TCW_ASSERT_NOW(a_row_range, 1'b1, row < ROW_W'(tcw_pkg::ROWS), "cursor row out of range")
  `TCW_ASSERT_NOW(a_no_result_in_init, init_busy, !out_valid, "result shown during reset sweep")
  `TCW_ASSERT_NEXT(a_scroll_to_blank, (state == S_SCROLL) && !(cnt < ADDR_W'(tcw_pkg::LAST_BASE)), (state == S_FILL) && (cnt == ADDR_W'(tcw_pkg::LAST_BASE)), "scroll did not hand over to bottom row blank")

endmodule

@@ rtl/text_console_writer_unit.sv @@
// Top level of the text console writer: front end, command queue and back end.
`timescale 1ns / 1ps
// Text console over an 80x25 store of 16-bit cells (attribute high, character low).
// Request channel in_valid/in_ready carries op, char_code and cell_index; each
// request yields exactly one result on out_valid/out_ready with the cursor after
// the request and, for a read, the cell (zero for other ops and out-of-range reads).
// The attribute register is written over cfg_valid/cfg_ready/cfg_data; write it
// only while no request is outstanding.
// Requests land in a two-entry queue; the back end works them one at a time.
// Throughput: one put, newline, backspace or no-op a cycle while out_ready is
// high; a read holds the back end in S_READ until the result register is free.
// A put or newline past the last row scrolls: the 1920 cells below the top row
// are copied one row up, the 80 cells of the bottom row are blanked, then the
// result is posted; a clear sweeps all 2000 cells and then posts.
// After reset the store is blanked with attribute 0x0F, one cell a cycle, over
// all 2000 cells; in_ready stays low meanwhile, configuration writes are taken.
// When out_ready is low the result holds in the output register; up to two more
// requests queue, then in_ready drops.
module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::OP_W-1:0]    op,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]  cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::ROW_W-1:0]   caret_row,
  output logic [tcw_pkg::COL_W-1:0]   caret_col,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

  logic                q_full;
  logic                q_valid;
  logic                push;
  logic                pop;
  logic                init_busy;
  tcw_pkg::cmd_entry_t push_entry;
  tcw_pkg::cmd_entry_t q_entry;

  assign cfg_ready = 1'b1;

  tcw_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .char_code  (char_code),
    .cell_index (cell_index),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .push       (push),
    .push_entry (push_entry)
  );

  tcw_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .caret_row  (caret_row),
    .caret_col  (caret_col),
    .cell_data  (cell_data)
  );

endmodule
